>>> design/dtca_pkg.sv
// ============================================================================
// dtca_pkg: shared types and constants
// Sizes, status codes and helpers for the directory table cluster allocator.
// ============================================================================
package dtca_pkg;

    localparam int TABLE_SLOTS = 128;
    localparam int CLUSTERS    = 4096;
    localparam int NAME_BYTES  = 11;

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
    localparam int CLUS_W  = $clog2(CLUSTERS);
    localparam int NAME_W  = 88;
    localparam int ENTRY_W = NAME_W + 1 + CLUS_W;

    typedef enum logic [1:0] {
        FN_FORMAT = 2'd0,
        FN_ADD    = 2'd1,
        FN_LOOKUP = 2'd2,
        FN_NONE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_NOCLUSTER = 3'd3,
        ST_NOTFOUND  = 3'd4
    } status_t;

    // Bytes after the first zero byte, or beyond NAME_BYTES, are cleared.
    function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] res;
        logic              live;
        res  = '0;
        live = 1'b1;
        for (int k = 0; k < 11; k++) begin
            if (raw[NAME_W-1-8*k -: 8] == 8'd0 || k >= NAME_BYTES) begin
                live = 1'b0;
            end
            if (live) begin
                res[NAME_W-1-8*k -: 8] = raw[NAME_W-1-8*k -: 8];
            end
        end
        return res;
    endfunction

endpackage

>>> design/dtca_ram.sv
// ============================================================================
// dtca_ram: generic single-port RAM
// One write and one read per cycle on a single address, registered read data.
// ============================================================================
module dtca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> design/directory_table_cluster_allocator_core.sv
// ============================================================================
// directory_table_cluster_allocator_core: name table with first-fit allocator
// Format, add and lookup items over a slot RAM and a cluster-map RAM.
// ============================================================================
//  channel | ports      | carries
//  input   | s_*        | func, name_head, name_tail, new_is_dir
//  result  | m_*        | status, entry_slot, entry_cluster, entry_is_dir, entry_count
//
//  One item at a time. Lookup: a read and then a compare per slot, and at
//  the end the result. Add: the same slot scan, then a read and a check per
//  cluster-map entry from 2 up, until a free entry is found.
//  Format: clears the map one entry per cycle, with entries 0 to 2 marked used.
//  After reset a clearing pass over all CLUSTERS map entries runs before s_ready rises.
//  A result waits in the output register; the next item is taken meanwhile.
module directory_table_cluster_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [63:0] s_name_head,
    input  logic [23:0] s_name_tail,
    input  logic        s_new_is_dir,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [6:0]  m_entry_slot,
    output logic [11:0] m_entry_cluster,
    output logic        m_entry_is_dir,
    output logic [7:0]  m_entry_count
);

    localparam int SW = dtca_pkg::SLOT_W;
    localparam int CW = dtca_pkg::CLUS_W;
    localparam int NW = dtca_pkg::CNT_W;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_SCAN  = 8'b00000100,
        S_CMP   = 8'b00001000,
        S_MAP   = 8'b00010000,
        S_MCHK  = 8'b00100000,
        S_DONE  = 8'b01000000,
        S_WAIT  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0]  func_reg, func_next;
    logic [dtca_pkg::NAME_W-1:0] name_reg, name_next;
    logic        dir_reg, dir_next;
    logic [NW-1:0] count_reg, count_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [CW:0] clus_reg, clus_next;
    logic        m_valid_reg, m_valid_next;
    logic [2:0]  st_reg, st_next;
    logic [6:0]  oslot_reg, oslot_next;
    logic [11:0] oclus_reg, oclus_next;
    logic        odir_reg, odir_next;

    logic                       slot_we;
    logic [SW-1:0]              slot_addr;
    logic [dtca_pkg::ENTRY_W-1:0] slot_wdata, slot_rdata;
    logic                       map_we;
    logic [CW-1:0]              map_addr;
    logic                       map_wdata, map_rdata;

    dtca_ram #(.WIDTH(dtca_pkg::ENTRY_W), .DEPTH(dtca_pkg::TABLE_SLOTS)) u_slot_ram (
        .aclk(aclk), .we(slot_we), .addr(slot_addr), .wdata(slot_wdata),
        .rdata(slot_rdata)
    );

    dtca_ram #(.WIDTH(1), .DEPTH(dtca_pkg::CLUSTERS)) u_map_ram (
        .aclk(aclk), .we(map_we), .addr(map_addr), .wdata(map_wdata),
        .rdata(map_rdata)
    );

    logic [dtca_pkg::NAME_W-1:0] slot_name;
    logic                        slot_dir;
    logic [CW-1:0]               slot_clus;
    assign slot_name = slot_rdata[dtca_pkg::ENTRY_W-1 -: dtca_pkg::NAME_W];
    assign slot_dir  = slot_rdata[CW];
    assign slot_clus = slot_rdata[CW-1:0];

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        name_next    = name_reg;
        dir_next     = dir_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        clus_next    = clus_reg;
        m_valid_next = m_valid_reg;
        st_next      = st_reg;
        oslot_next   = oslot_reg;
        oclus_next   = oclus_reg;
        odir_next    = odir_reg;
        slot_we      = 1'b0;
        slot_addr    = idx_reg[SW-1:0];
        slot_wdata   = {name_reg, dir_reg, clus_reg[CW-1:0]};
        map_we       = 1'b0;
        map_addr     = clus_reg[CW-1:0];
        map_wdata    = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_wdata = (clus_reg < (CW+1)'(3));
                clus_next = clus_reg + 1'b1;
                if (clus_reg == (CW+1)'(dtca_pkg::CLUSTERS - 1)) begin
                    state_next = (func_reg == dtca_pkg::FN_FORMAT) ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    func_next = s_func;
                    name_next = dtca_pkg::canon_name({s_name_head, s_name_tail});
                    dir_next  = s_new_is_dir;
                    idx_next  = '0;
                    clus_next = '0;
                    st_next   = dtca_pkg::ST_OK;
                    oslot_next = '0;
                    oclus_next = '0;
                    odir_next  = 1'b0;
                    priority case (s_func)
                        dtca_pkg::FN_NONE:   state_next = S_IDLE;
                        dtca_pkg::FN_FORMAT: begin
                            count_next = '0;
                            state_next = S_CLEAR;
                        end
                        default: begin
                            if (s_func == dtca_pkg::FN_ADD &&
                                count_reg >= NW'(dtca_pkg::TABLE_SLOTS)) begin
                                st_next    = dtca_pkg::ST_FULL;
                                state_next = S_DONE;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // issue read of slot idx, or end of table reached
                if (idx_reg >= count_reg) begin
                    if (func_reg == dtca_pkg::FN_ADD) begin
                        clus_next  = (CW+1)'(2);
                        state_next = S_MAP;
                    end else begin
                        st_next    = dtca_pkg::ST_NOTFOUND;
                        state_next = S_DONE;
                    end
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (slot_name == name_reg) begin
                    if (func_reg == dtca_pkg::FN_ADD) begin
                        st_next = dtca_pkg::ST_EXISTS;
                    end else begin
                        oslot_next = 7'(idx_reg);
                        oclus_next = 12'(slot_clus);
                        odir_next  = slot_dir;
                    end
                    state_next = S_DONE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_MAP: begin
                if (clus_reg == (CW+1)'(dtca_pkg::CLUSTERS)) begin
                    st_next    = dtca_pkg::ST_NOCLUSTER;
                    state_next = S_DONE;
                end else begin
                    state_next = S_MCHK;
                end
            end
            S_MCHK: begin
                if (!map_rdata) begin
                    map_we     = 1'b1;
                    map_wdata  = 1'b1;
                    slot_we    = 1'b1;
                    slot_addr  = count_reg[SW-1:0];
                    oslot_next = 7'(count_reg);
                    oclus_next = 12'(clus_reg);
                    odir_next  = dir_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_DONE;
                end else begin
                    clus_next  = clus_reg + 1'b1;
                    state_next = S_MAP;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_WAIT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            func_reg    <= dtca_pkg::FN_NONE;
            count_reg   <= '0;
            clus_reg    <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            func_reg    <= func_next;
            count_reg   <= count_next;
            clus_reg    <= clus_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        name_reg <= name_next;
        dir_reg  <= dir_next;
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            st_reg    <= st_next;
            oslot_reg <= oslot_next;
            oclus_reg <= oclus_next;
            odir_reg  <= odir_next;
        end else if (state_reg != S_DONE) begin
            st_reg    <= st_next;
            oslot_reg <= oslot_next;
            oclus_reg <= oclus_next;
            odir_reg  <= odir_next;
        end
    end

    // result fields are copied into the output register when it is loaded
    logic [2:0]  ms_reg;
    logic [6:0]  mslot_reg;
    logic [11:0] mclus_reg;
    logic        mdir_reg;
    logic [7:0]  mcnt_reg;
    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            ms_reg    <= st_reg;
            mslot_reg <= oslot_reg;
            mclus_reg <= oclus_reg;
            mdir_reg  <= odir_reg;
            mcnt_reg  <= 8'(count_reg);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = ms_reg;
    assign m_entry_slot    = mslot_reg;
    assign m_entry_cluster = mclus_reg;
    assign m_entry_is_dir  = mdir_reg;
    assign m_entry_count   = mcnt_reg;

endmodule

>>> design/dtca_checker.sv
// ============================================================================
// dtca_checker: port-level checks
// Result channel hold and result field sanity over time.
// ============================================================================
module dtca_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [6:0]  m_entry_slot,
    input logic [11:0] m_entry_cluster,
    input logic [7:0]  m_entry_count
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_entry_count))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= dtca_pkg::ST_NOTFOUND)
        else $error("bad status");

    // a good add or lookup names a slot below the count, unless the table holds 128
    a_ok_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == dtca_pkg::ST_OK && m_entry_count != 8'd0
        |-> m_entry_slot < 7'(m_entry_count) || m_entry_count == 8'd128)
        else $error("entry slot beyond table");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entry_count <= 8'd128 && (m_entry_count == 8'd0 ||
                    m_status != dtca_pkg::ST_OK || m_entry_cluster >= 12'd2 ||
                    m_entry_cluster == 12'd0))
        else $error("count out of range");

    // the map clearing pass follows reset, so no item is taken right after it
    a_reset: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("ready right after reset");

endmodule

bind directory_table_cluster_allocator_core dtca_checker u_dtca_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_entry_slot(m_entry_slot), .m_entry_cluster(m_entry_cluster),
    .m_entry_count(m_entry_count)
);
